[rtl/ttf_pkg.sv]
// Shared types, codes and constants of the triangle tangent frame unit.
package ttf_pkg;

   // Default field widths and the reduced magnitude width before normalizing
   localparam int COORD_WIDTH_DEF = 32;
   localparam int UNIT_WIDTH_DEF  = 16;
   localparam int RED_BITS        = 24;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_IDLE      = 4'd0,
      OP_STORE     = 4'd1,
      OP_DELTA     = 4'd2,
      OP_MUL       = 4'd3,
      OP_ACC       = 4'd4,
      OP_ABS       = 4'd5,
      OP_SHIFT     = 4'd6,
      OP_SDIR      = 4'd7,
      OP_LOADN     = 4'd8,
      OP_FLOOR     = 4'd9,
      OP_SQRT_INIT = 4'd10,
      OP_SQRT      = 4'd11,
      OP_DIV_INIT  = 4'd12,
      OP_DIV       = 4'd13,
      OP_DIV_DONE  = 4'd14,
      OP_EMIT      = 4'd15
   } op_type;

   // Product groups run through the shared multiplier
   typedef enum logic [2:0] {
      GRP_SD  = 3'd0,
      GRP_DOT = 3'd1,
      GRP_G   = 3'd2,
      GRP_SQ  = 3'd3,
      GRP_CR  = 3'd4
   } grp_type;

   typedef struct packed {
      op_type     op;
      grp_type    grp;
      logic [2:0] idx;
      logic [1:0] vtx;
      logic [1:0] phase;
      logic       norm;
      logic       pass;
   } cmd_type;

   typedef struct packed {
      logic red_more;
      logic mag_zero;
      logic det_zero;
      logic out_free;
   } status_type;

endpackage

[rtl/triangle_tangent_frame_unit.sv]
// Top level of the triangle tangent frame unit: controller, datapath and checks.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | vertex position, texcoord, normal
//   rsp     | out       | rsp_valid / rsp_stall   | tangent, binormal, degenerate, last
//
// The first two vertices of a triangle are only stored; the third starts the setup
// and then the three results, no new vertex being taken until the last is emitted.
// The bit-serial square root (25 steps) and the three divisions (UNIT_WIDTH-1 steps
// each), run twice per vertex, do most of the work. Reset is synchronous and clears
// the state machine, the vertex count and the result valid. A stalled result
// holds in the output register while the next result is being computed.
module triangle_tangent_frame_unit #(
   parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
   parameter int UNIT_WIDTH  = ttf_pkg::UNIT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_tex_u,
   input  logic signed [COORD_WIDTH-1:0] req_tex_v,
   input  logic signed [UNIT_WIDTH-1:0]  req_norm_x,
   input  logic signed [UNIT_WIDTH-1:0]  req_norm_y,
   input  logic signed [UNIT_WIDTH-1:0]  req_norm_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [UNIT_WIDTH-1:0]  rsp_tangent_x,
   output logic signed [UNIT_WIDTH-1:0]  rsp_tangent_y,
   output logic signed [UNIT_WIDTH-1:0]  rsp_tangent_z,
   output logic signed [UNIT_WIDTH-1:0]  rsp_binormal_x,
   output logic signed [UNIT_WIDTH-1:0]  rsp_binormal_y,
   output logic signed [UNIT_WIDTH-1:0]  rsp_binormal_z,
   output logic                          rsp_degenerate,
   output logic                          rsp_last_of_triangle
);

   ttf_pkg::cmd_type    cmd;
   ttf_pkg::status_type status;

   ttf_ctrl #(
      .UNIT_WIDTH(UNIT_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   ttf_datapath #(
      .COORD_WIDTH(COORD_WIDTH),
      .UNIT_WIDTH (UNIT_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_tex_u           (req_tex_u),
      .req_tex_v           (req_tex_v),
      .req_norm_x          (req_norm_x),
      .req_norm_y          (req_norm_y),
      .req_norm_z          (req_norm_z),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tangent_x       (rsp_tangent_x),
      .rsp_tangent_y       (rsp_tangent_y),
      .rsp_tangent_z       (rsp_tangent_z),
      .rsp_binormal_x      (rsp_binormal_x),
      .rsp_binormal_y      (rsp_binormal_y),
      .rsp_binormal_z      (rsp_binormal_z),
      .rsp_degenerate      (rsp_degenerate),
      .rsp_last_of_triangle(rsp_last_of_triangle)
   );

   // An accepted vertex is always written to the store
   a_accept_stores: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cmd.op == ttf_pkg::OP_STORE))
      else $error("accepted vertex not stored");

   // A new result never overwrites one that is still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ttf_pkg::OP_EMIT) |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // A degenerate result carries zero vectors
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_tangent_x == '0 && rsp_tangent_y == '0 && rsp_tangent_z == '0 &&
          rsp_binormal_x == '0 && rsp_binormal_y == '0 && rsp_binormal_z == '0))
      else $error("degenerate result with nonzero vector");

endmodule

[rtl/ttf_ctrl.sv]
// Sequencing state machine of the triangle tangent frame unit.
module ttf_ctrl #(
   parameter int UNIT_WIDTH = ttf_pkg::UNIT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ttf_pkg::status_type status,
   output ttf_pkg::cmd_type    cmd
);

   localparam int F       = UNIT_WIDTH - 2;
   localparam int RED     = ttf_pkg::RED_BITS;
   localparam int CNT_MAX = ttf_pkg::max_int(RED, F);
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   typedef enum logic [14:0] {
      ST_IDLE      = 15'h0001,
      ST_DELTA     = 15'h0002,
      ST_MUL       = 15'h0004,
      ST_ACC       = 15'h0008,
      ST_ABS       = 15'h0010,
      ST_SHIFT     = 15'h0020,
      ST_SDIR      = 15'h0040,
      ST_LOADN     = 15'h0080,
      ST_FLOOR     = 15'h0100,
      ST_SQRT_INIT = 15'h0200,
      ST_SQRT      = 15'h0400,
      ST_DIV_INIT  = 15'h0800,
      ST_DIV       = 15'h1000,
      ST_DIV_DONE  = 15'h2000,
      ST_EMIT      = 15'h4000
   } state_type;

   state_type        state_ff, state_in;
   ttf_pkg::grp_type grp_ff, grp_in;
   logic [2:0]       idx_ff, idx_in;
   logic [1:0]       vtx_ff, vtx_in;
   logic [1:0]       phase_ff, phase_in;
   logic             norm_ff, norm_in;
   logic             pass_ff, pass_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       grp_last;

   // Last product index of each group
   always_comb begin
      unique case (grp_ff)
         ttf_pkg::GRP_SD:  grp_last = 3'd7;
         ttf_pkg::GRP_CR:  grp_last = 3'd5;
         default:          grp_last = 3'd2;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command
   always_comb begin
      state_in  = state_ff;
      grp_in    = grp_ff;
      idx_in    = idx_ff;
      vtx_in    = vtx_ff;
      phase_in  = phase_ff;
      norm_in   = norm_ff;
      pass_in   = pass_ff;
      cnt_in    = cnt_ff;
      cmd.op    = ttf_pkg::OP_IDLE;
      cmd.grp   = grp_ff;
      cmd.idx   = idx_ff;
      cmd.vtx   = vtx_ff;
      cmd.phase = phase_ff;
      cmd.norm  = norm_ff;
      cmd.pass  = pass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = ttf_pkg::OP_STORE;
               if (phase_ff == 2'd2) begin
                  phase_in = 2'd0;
                  state_in = ST_DELTA;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_DELTA: begin
            cmd.op   = ttf_pkg::OP_DELTA;
            grp_in   = ttf_pkg::GRP_SD;
            idx_in   = 3'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = ttf_pkg::OP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op = ttf_pkg::OP_ACC;
            if (idx_ff == grp_last) begin
               idx_in = 3'd0;
               unique case (grp_ff)
                  ttf_pkg::GRP_SD: begin
                     norm_in  = 1'b0;
                     state_in = ST_ABS;
                  end
                  ttf_pkg::GRP_DOT: state_in = ST_FLOOR;
                  ttf_pkg::GRP_SQ:  state_in = ST_SQRT_INIT;
                  default: begin
                     norm_in  = 1'b1;
                     state_in = ST_ABS;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_ABS: begin
            cmd.op   = ttf_pkg::OP_ABS;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.op = ttf_pkg::OP_SHIFT;
            if (!status.red_more) begin
               if (!norm_ff) begin
                  state_in = ST_SDIR;
               end else if (status.mag_zero) begin
                  state_in = ST_EMIT;
               end else begin
                  grp_in   = ttf_pkg::GRP_SQ;
                  idx_in   = 3'd0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_SDIR: begin
            cmd.op   = ttf_pkg::OP_SDIR;
            vtx_in   = 2'd0;
            state_in = ST_LOADN;
         end
         ST_LOADN: begin
            cmd.op  = ttf_pkg::OP_LOADN;
            pass_in = 1'b0;
            if (status.det_zero) begin
               state_in = ST_EMIT;
            end else begin
               grp_in   = ttf_pkg::GRP_DOT;
               idx_in   = 3'd0;
               state_in = ST_MUL;
            end
         end
         ST_FLOOR: begin
            cmd.op   = ttf_pkg::OP_FLOOR;
            grp_in   = ttf_pkg::GRP_G;
            idx_in   = 3'd0;
            state_in = ST_MUL;
         end
         ST_SQRT_INIT: begin
            cmd.op   = ttf_pkg::OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = ttf_pkg::OP_SQRT;
            if (cnt_ff == CNT_W'(RED)) begin
               idx_in   = 3'd0;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV_INIT: begin
            cmd.op   = ttf_pkg::OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = ttf_pkg::OP_DIV;
            if (cnt_ff == CNT_W'(F)) begin
               state_in = ST_DIV_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV_DONE: begin
            cmd.op = ttf_pkg::OP_DIV_DONE;
            if (idx_ff == 3'd2) begin
               idx_in = 3'd0;
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  grp_in   = ttf_pkg::GRP_CR;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op = ttf_pkg::OP_EMIT;
               if (vtx_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  vtx_in   = vtx_ff + 2'd1;
                  state_in = ST_LOADN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         grp_ff   <= ttf_pkg::GRP_SD;
         idx_ff   <= 3'd0;
         vtx_ff   <= 2'd0;
         phase_ff <= 2'd0;
         norm_ff  <= 1'b0;
         pass_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         idx_ff   <= idx_in;
         vtx_ff   <= vtx_in;
         phase_ff <= phase_in;
         norm_ff  <= norm_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/ttf_datapath.sv]
// Vertex storage, shared multiplier, square root and divider of the tangent frame unit.
module ttf_datapath #(
   parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF,
   parameter int UNIT_WIDTH  = ttf_pkg::UNIT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ttf_pkg::cmd_type              cmd,
   output ttf_pkg::status_type           status,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_tex_u,
   input  logic signed [COORD_WIDTH-1:0] req_tex_v,
   input  logic signed [UNIT_WIDTH-1:0]  req_norm_x,
   input  logic signed [UNIT_WIDTH-1:0]  req_norm_y,
   input  logic signed [UNIT_WIDTH-1:0]  req_norm_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [UNIT_WIDTH-1:0]  rsp_tangent_x,
   output logic signed [UNIT_WIDTH-1:0]  rsp_tangent_y,
   output logic signed [UNIT_WIDTH-1:0]  rsp_tangent_z,
   output logic signed [UNIT_WIDTH-1:0]  rsp_binormal_x,
   output logic signed [UNIT_WIDTH-1:0]  rsp_binormal_y,
   output logic signed [UNIT_WIDTH-1:0]  rsp_binormal_z,
   output logic                          rsp_degenerate,
   output logic                          rsp_last_of_triangle
);

   localparam int F   = UNIT_WIDTH - 2;
   localparam int RED = ttf_pkg::RED_BITS;
   localparam int DW  = COORD_WIDTH + 1;
   localparam int SW  = RED + 1;
   localparam int D_W = UNIT_WIDTH + RED + 3 - F;
   localparam int MW  = ttf_pkg::max_int(ttf_pkg::max_int(DW, D_W),
                                         ttf_pkg::max_int(UNIT_WIDTH, SW));
   localparam int PW  = 2 * MW;
   localparam int QW  = 2 * RED + 2;
   localparam int V_W = ttf_pkg::max_int(ttf_pkg::max_int(2 * COORD_WIDTH + 3, PW + 1),
                                         ttf_pkg::max_int(RED + F + 2, QW));
   localparam int LW  = RED + 1;
   localparam int NW  = RED + F + 1;
   localparam int RW  = RED + 2;

   // Vertex store: rows are vertices one to three
   logic signed [COORD_WIDTH-1:0] pos_ff [3][3];
   logic signed [COORD_WIDTH-1:0] tex_ff [3][2];
   logic signed [UNIT_WIDTH-1:0]  nrm_ff [3][3];

   logic signed [DW-1:0]  e_ff [6];
   logic signed [DW-1:0]  st_ff [4];
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [MW-1:0]  op_a, op_b;
   logic signed [V_W-1:0] acc_ff, acc_in;
   logic signed [V_W-1:0] v_ff [3];
   logic signed [V_W-1:0] v_in [3];
   logic [V_W-1:0]        vmag_ff [3];
   logic [V_W-1:0]        vmag_in [3];
   logic                  vneg_ff [3];
   logic                  vneg_in [3];
   logic                  det_zero_ff, det_zero_in, det_neg_ff, det_neg_in;
   logic signed [SW-1:0]  s_ff [3];
   logic signed [SW-1:0]  s_in [3];
   logic signed [UNIT_WIDTH-1:0] cur_n_ff [3];
   logic signed [D_W-1:0] d_ff, d_in;
   logic [QW-1:0]         sq_x_ff, sq_x_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [QW-1:0]         sq_trial;
   logic [F:0]            num_lo_ff, num_lo_in, q_ff, q_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [RW:0]           div_trial, len_ext;
   logic [NW-1:0]         num;
   logic [LW-1:0]         len;
   logic signed [UNIT_WIDTH-1:0] tan_ff [3];
   logic signed [UNIT_WIDTH-1:0] tan_in [3];
   logic signed [UNIT_WIDTH-1:0] bin_ff [3];
   logic signed [UNIT_WIDTH-1:0] bin_in [3];
   logic signed [UNIT_WIDTH-1:0] qs;
   logic                  degen_ff, degen_in;
   logic [V_W-1:0]        or_all;
   logic                  more8, more1;
   logic signed [V_W-1:0] pext, diff, s_sh;
   logic [1:0]            ix;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [UNIT_WIDTH-1:0] o_tan_ff [3];
   logic signed [UNIT_WIDTH-1:0] o_bin_ff [3];
   logic                  o_degen_ff, o_last_ff;

   assign ix     = cmd.idx[1:0];
   assign or_all = vmag_ff[0] | vmag_ff[1] | vmag_ff[2];
   assign more8  = |or_all[V_W-1:RED+8];
   assign more1  = |or_all[V_W-1:RED];
   assign len    = sq_r_ff[LW-1:0];
   assign pext   = V_W'(prod_ff);

   assign status.red_more = more1;
   assign status.mag_zero = (or_all == '0);
   assign status.det_zero = det_zero_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Select multiplier operands
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.grp)
         ttf_pkg::GRP_SD: begin
            unique case (cmd.idx)
               3'd0: begin op_a = MW'(st_ff[0]); op_b = MW'(st_ff[3]); end
               3'd1: begin op_a = MW'(st_ff[2]); op_b = MW'(st_ff[1]); end
               3'd2: begin op_a = MW'(st_ff[3]); op_b = MW'(e_ff[0]); end
               3'd3: begin op_a = MW'(st_ff[1]); op_b = MW'(e_ff[3]); end
               3'd4: begin op_a = MW'(st_ff[3]); op_b = MW'(e_ff[1]); end
               3'd5: begin op_a = MW'(st_ff[1]); op_b = MW'(e_ff[4]); end
               3'd6: begin op_a = MW'(st_ff[3]); op_b = MW'(e_ff[2]); end
               default: begin op_a = MW'(st_ff[1]); op_b = MW'(e_ff[5]); end
            endcase
         end
         ttf_pkg::GRP_DOT: begin
            op_a = MW'(cur_n_ff[ix]);
            op_b = MW'(s_ff[ix]);
         end
         ttf_pkg::GRP_G: begin
            op_a = MW'(cur_n_ff[ix]);
            op_b = MW'(d_ff);
         end
         ttf_pkg::GRP_SQ: begin
            op_a = MW'(vmag_ff[ix][RED-1:0]);
            op_b = MW'(vmag_ff[ix][RED-1:0]);
         end
         ttf_pkg::GRP_CR: begin
            unique case (cmd.idx)
               3'd0: begin op_a = MW'(cur_n_ff[1]); op_b = MW'(tan_ff[2]); end
               3'd1: begin op_a = MW'(cur_n_ff[2]); op_b = MW'(tan_ff[1]); end
               3'd2: begin op_a = MW'(cur_n_ff[2]); op_b = MW'(tan_ff[0]); end
               3'd3: begin op_a = MW'(cur_n_ff[0]); op_b = MW'(tan_ff[2]); end
               3'd4: begin op_a = MW'(cur_n_ff[0]); op_b = MW'(tan_ff[1]); end
               default: begin op_a = MW'(cur_n_ff[1]); op_b = MW'(tan_ff[0]); end
            endcase
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in  = PW'(op_a) * PW'(op_b);
   assign diff     = acc_ff - pext;
   assign s_sh     = V_W'(s_ff[ix]) <<< F;
   assign sq_trial = sq_r_ff + sq_bit_ff;
   assign num      = (NW'(vmag_ff[ix][RED-1:0]) << F) + NW'(len >> 1);
   assign div_trial = {rem_ff, num_lo_ff[F]};
   assign len_ext  = (RW + 1)'(len);
   assign qs       = UNIT_WIDTH'(q_ff);

   // Datapath next values
   always_comb begin
      acc_in      = acc_ff;
      v_in        = v_ff;
      vmag_in     = vmag_ff;
      vneg_in     = vneg_ff;
      det_zero_in = det_zero_ff;
      det_neg_in  = det_neg_ff;
      s_in        = s_ff;
      d_in        = d_ff;
      sq_x_in     = sq_x_ff;
      sq_r_in     = sq_r_ff;
      sq_bit_in   = sq_bit_ff;
      num_lo_in   = num_lo_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      tan_in      = tan_ff;
      bin_in      = bin_ff;
      degen_in    = degen_ff;
      unique case (cmd.op)
         ttf_pkg::OP_ACC: begin
            unique case (cmd.grp)
               ttf_pkg::GRP_SD: begin
                  if (!cmd.idx[0]) begin
                     acc_in = pext;
                  end else if (cmd.idx[2:1] == 2'd0) begin
                     det_zero_in = (diff == '0);
                     det_neg_in  = diff[V_W-1];
                  end else begin
                     v_in[2'(cmd.idx[2:1] - 2'd1)] = diff;
                  end
               end
               ttf_pkg::GRP_CR: begin
                  if (!cmd.idx[0]) begin
                     acc_in = pext;
                  end else begin
                     v_in[cmd.idx[2:1]] = diff;
                  end
               end
               ttf_pkg::GRP_G: v_in[ix] = s_sh - pext;
               default: acc_in = ((cmd.idx == 3'd0) ? '0 : acc_ff) + pext;
            endcase
         end
         ttf_pkg::OP_ABS: begin
            for (int i = 0; i < 3; i++) begin
               vneg_in[i] = v_ff[i][V_W-1];
               vmag_in[i] = v_ff[i][V_W-1] ? V_W'(-v_ff[i]) : V_W'(v_ff[i]);
            end
         end
         ttf_pkg::OP_SHIFT: begin
            for (int i = 0; i < 3; i++) begin
               if (more8) begin
                  vmag_in[i] = vmag_ff[i] >> 8;
               end else if (more1) begin
                  vmag_in[i] = vmag_ff[i] >> 1;
               end
            end
            if (cmd.norm && !more1 && (or_all == '0)) begin
               degen_in = 1'b1;
            end
         end
         ttf_pkg::OP_SDIR: begin
            for (int i = 0; i < 3; i++) begin
               s_in[i] = (vneg_ff[i] ^ det_neg_ff) ?
                         -$signed({1'b0, vmag_ff[i][RED-1:0]}) :
                         $signed({1'b0, vmag_ff[i][RED-1:0]});
            end
         end
         ttf_pkg::OP_LOADN: degen_in = det_zero_ff;
         ttf_pkg::OP_FLOOR: d_in = D_W'(acc_ff >>> F);
         ttf_pkg::OP_SQRT_INIT: begin
            sq_x_in   = acc_ff[QW-1:0];
            sq_r_in   = '0;
            sq_bit_in = QW'(1) << (2 * RED);
         end
         ttf_pkg::OP_SQRT: begin
            if (sq_x_ff >= sq_trial) begin
               sq_x_in = sq_x_ff - sq_trial;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         ttf_pkg::OP_DIV_INIT: begin
            rem_in    = RW'(num >> (F + 1));
            num_lo_in = num[F:0];
            q_in      = '0;
         end
         ttf_pkg::OP_DIV: begin
            if (div_trial >= len_ext) begin
               rem_in = RW'(div_trial - len_ext);
               q_in   = {q_ff[F-1:0], 1'b1};
            end else begin
               rem_in = RW'(div_trial);
               q_in   = {q_ff[F-1:0], 1'b0};
            end
            num_lo_in = num_lo_ff << 1;
         end
         ttf_pkg::OP_DIV_DONE: begin
            if (cmd.pass) begin
               bin_in[ix] = vneg_ff[ix] ? -qs : qs;
            end else begin
               tan_in[ix] = vneg_ff[ix] ? -qs : qs;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == ttf_pkg::OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == ttf_pkg::OP_STORE) begin
         pos_ff[cmd.phase][0] <= req_pos_x;
         pos_ff[cmd.phase][1] <= req_pos_y;
         pos_ff[cmd.phase][2] <= req_pos_z;
         tex_ff[cmd.phase][0] <= req_tex_u;
         tex_ff[cmd.phase][1] <= req_tex_v;
         nrm_ff[cmd.phase][0] <= req_norm_x;
         nrm_ff[cmd.phase][1] <= req_norm_y;
         nrm_ff[cmd.phase][2] <= req_norm_z;
      end
      if (cmd.op == ttf_pkg::OP_DELTA) begin
         for (int i = 0; i < 3; i++) begin
            e_ff[i]     <= DW'(pos_ff[1][i]) - DW'(pos_ff[0][i]);
            e_ff[3 + i] <= DW'(pos_ff[2][i]) - DW'(pos_ff[0][i]);
         end
         st_ff[0] <= DW'(tex_ff[1][0]) - DW'(tex_ff[0][0]);
         st_ff[1] <= DW'(tex_ff[1][1]) - DW'(tex_ff[0][1]);
         st_ff[2] <= DW'(tex_ff[2][0]) - DW'(tex_ff[0][0]);
         st_ff[3] <= DW'(tex_ff[2][1]) - DW'(tex_ff[0][1]);
      end
      if (cmd.op == ttf_pkg::OP_LOADN) begin
         for (int i = 0; i < 3; i++) begin
            cur_n_ff[i] <= nrm_ff[cmd.vtx][i];
         end
      end
      if (cmd.op == ttf_pkg::OP_MUL) begin
         prod_ff <= prod_in;
      end
      if (cmd.op == ttf_pkg::OP_EMIT) begin
         for (int i = 0; i < 3; i++) begin
            o_tan_ff[i] <= degen_ff ? '0 : tan_ff[i];
            o_bin_ff[i] <= degen_ff ? '0 : bin_ff[i];
         end
         o_degen_ff <= degen_ff;
         o_last_ff  <= (cmd.vtx == 2'd2);
      end
      acc_ff      <= acc_in;
      v_ff        <= v_in;
      vmag_ff     <= vmag_in;
      vneg_ff     <= vneg_in;
      det_zero_ff <= det_zero_in;
      det_neg_ff  <= det_neg_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      sq_x_ff     <= sq_x_in;
      sq_r_ff     <= sq_r_in;
      sq_bit_ff   <= sq_bit_in;
      num_lo_ff   <= num_lo_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      tan_ff      <= tan_in;
      bin_ff      <= bin_in;
      degen_ff    <= degen_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tangent_x        = o_tan_ff[0];
   assign rsp_tangent_y        = o_tan_ff[1];
   assign rsp_tangent_z        = o_tan_ff[2];
   assign rsp_binormal_x       = o_bin_ff[0];
   assign rsp_binormal_y       = o_bin_ff[1];
   assign rsp_binormal_z       = o_bin_ff[2];
   assign rsp_degenerate       = o_degen_ff;
   assign rsp_last_of_triangle = o_last_ff;

endmodule

[sim/tb.sv]
// Testbench for the triangle tangent frame unit: directed table, then random triangles.
`timescale 1ns / 1ps

module tb;

   localparam int  CW        = ttf_pkg::COORD_WIDTH_DEF;
   localparam int  UW        = ttf_pkg::UNIT_WIDTH_DEF;
   localparam int  RB        = ttf_pkg::RED_BITS;
   localparam int  FB        = UW - 2;
   localparam int  QONE      = 65536;
   localparam int  RAND_TRIS = 131;
   localparam int  LIMIT     = 1500000;
   localparam int  HOLD_AT   = 6000;
   localparam int  HOLD_LEN  = 4000;
   localparam int  QUIET_AT  = 30000;
   localparam int  QUIET_LEN = 12000;

   typedef struct {
      logic signed [CW-1:0] px, py, pz, tu, tv;
      logic signed [UW-1:0] nx, ny, nz;
   } vertex_type;

   typedef struct {
      logic signed [UW-1:0] tx, ty, tz, bx, by, bz;
      bit                   degen, last;
   } frame_type;

   // one row of the directed table; known marks a third vertex whose frames are degenerate
   typedef struct {
      vertex_type v;
      bit         known;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CW-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [CW-1:0] req_tex_u = 0, req_tex_v = 0;
   logic signed [UW-1:0] req_norm_x = 0, req_norm_y = 0, req_norm_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [UW-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic signed [UW-1:0] rsp_binormal_x, rsp_binormal_y, rsp_binormal_z;
   logic rsp_degenerate, rsp_last_of_triangle;

   frame_type  frames_due[$];
   vertex_type held_vtx[2];
   int         vtx_count = 0;
   int         errors = 0;
   int         cycle = 0;
   bit         hold_off = 0;
   row_type    dir_rows[18];

   triangle_tangent_frame_unit dut (.*);

   always #4 clock = ~clock;

   function automatic bit quiet();
      return cycle >= QUIET_AT && cycle < QUIET_AT + QUIET_LEN;
   endfunction

   function automatic logic signed [127:0] wide(input longint a);
      return 128'(a);
   endfunction

   function automatic int bits_of(input logic [127:0] m);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) if (m[i]) n = i + 1;
      return n;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // scale to unit length in Q1.14; zero vector gives 0
   function automatic bit unit_vector(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, acc, len, q;
      int k;
      mx = 0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 0;
      k = bits_of(128'(mx)) > RB ? bits_of(128'(mx)) - RB : 0;
      for (int i = 0; i < 3; i++) begin
         m[i] >>= k;
         acc += m[i] * m[i];
      end
      len = int_sqrt(acc);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FB) + len / 2) / len;
         if (q > 32767) q = 32767;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   // tangent frames for the three vertices of a triangle
   task automatic predict_frames(input vertex_type c);
      vertex_type vs[3];
      longint e[6], s[3], n[3], g[3], tg[3], cr[3], bn[3], s1, t1, s2, t2, d;
      logic signed [127:0] det, sd[3];
      logic [127:0] sm[3];
      bit flip, ok;
      int bl, k;
      frame_type f;
      vs[0] = held_vtx[0];
      vs[1] = held_vtx[1];
      vs[2] = c;
      for (int i = 0; i < 2; i++) begin
         e[3*i]   = longint'(vs[i+1].px) - longint'(vs[0].px);
         e[3*i+1] = longint'(vs[i+1].py) - longint'(vs[0].py);
         e[3*i+2] = longint'(vs[i+1].pz) - longint'(vs[0].pz);
      end
      s1 = longint'(vs[1].tu) - longint'(vs[0].tu);
      t1 = longint'(vs[1].tv) - longint'(vs[0].tv);
      s2 = longint'(vs[2].tu) - longint'(vs[0].tu);
      t2 = longint'(vs[2].tv) - longint'(vs[0].tv);
      det = wide(s1) * wide(t2) - wide(s2) * wide(t1);
      flip = det < 0;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
         sd[i] = wide(t2) * wide(e[i]) - wide(t1) * wide(e[i+3]);
         sm[i] = sd[i] < 0 ? -sd[i] : sd[i];
         if (bits_of(sm[i]) > bl) bl = bits_of(sm[i]);
      end
      k = bl > RB ? bl - RB : 0;
      for (int i = 0; i < 3; i++) begin
         s[i] = longint'(sm[i] >> k);
         if ((sd[i] < 0) != flip) s[i] = -s[i];
      end
      for (int j = 0; j < 3; j++) begin
         n[0] = longint'(vs[j].nx);
         n[1] = longint'(vs[j].ny);
         n[2] = longint'(vs[j].nz);
         ok = det != 0;
         if (ok) begin
            d = (n[0]*s[0] + n[1]*s[1] + n[2]*s[2]) >>> FB;
            for (int i = 0; i < 3; i++) g[i] = s[i] * (64'sd1 << FB) - n[i] * d;
            ok = unit_vector(g, tg);
         end
         if (ok) begin
            cr[0] = n[1]*tg[2] - n[2]*tg[1];
            cr[1] = n[2]*tg[0] - n[0]*tg[2];
            cr[2] = n[0]*tg[1] - n[1]*tg[0];
            ok = unit_vector(cr, bn);
         end
         f.tx = ok ? UW'(tg[0]) : '0;
         f.ty = ok ? UW'(tg[1]) : '0;
         f.tz = ok ? UW'(tg[2]) : '0;
         f.bx = ok ? UW'(bn[0]) : '0;
         f.by = ok ? UW'(bn[1]) : '0;
         f.bz = ok ? UW'(bn[2]) : '0;
         f.degen = !ok;
         f.last = j == 2;
         frames_due = {frames_due, f};
      end
   endtask

   // take one accepted vertex into the expectation store
   task automatic accept_vertex(input vertex_type v, input bit known);
      frame_type z;
      if (vtx_count < 2) begin
         held_vtx[vtx_count] = v;
         vtx_count++;
      end else begin
         vtx_count = 0;
         if (known) begin
            z = '{0, 0, 0, 0, 0, 0, 1, 0};
            frames_due = {frames_due, z};
            frames_due = {frames_due, z};
            z.last = 1;
            frames_due = {frames_due, z};
         end else begin
            predict_frames(v);
         end
      end
   endtask

   // offer one vertex and hold it until taken
   task automatic send_vertex(input vertex_type v, input bit known);
      if (!quiet() && !hold_off && $urandom_range(0, 99) < 35) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid  <= 1;
      req_pos_x  <= v.px;
      req_pos_y  <= v.py;
      req_pos_z  <= v.pz;
      req_tex_u  <= v.tu;
      req_tex_v  <= v.tv;
      req_norm_x <= v.nx;
      req_norm_y <= v.ny;
      req_norm_z <= v.nz;
      do @(posedge clock); while (req_stall);
      accept_vertex(v, known);
   endtask

   function automatic vertex_type mk(input longint px, py, pz, tu, tv, input int nx, ny, nz);
      vertex_type v;
      v.px = CW'(px); v.py = CW'(py); v.pz = CW'(pz); v.tu = CW'(tu); v.tv = CW'(tv);
      v.nx = UW'(nx); v.ny = UW'(ny); v.nz = UW'(nz);
      return v;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord(input bit wild);
      if (wild) return $urandom;
      return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
   endfunction

   function automatic vertex_type rand_vertex(input bit wild);
      vertex_type v;
      v.px = rand_coord(wild);
      v.py = rand_coord(wild);
      v.pz = rand_coord(wild);
      v.tu = rand_coord(wild);
      v.tv = rand_coord(wild);
      if (wild) begin
         v.nx = UW'($urandom);
         v.ny = UW'($urandom);
         v.nz = UW'($urandom);
      end else begin
         v.nx = UW'($signed($urandom_range(0, 32768)) - 16384);
         v.ny = UW'($signed($urandom_range(0, 32768)) - 16384);
         v.nz = UW'($signed($urandom_range(0, 32768)) - 16384);
      end
      return v;
   endfunction

   // cycle count and watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // long receiver hold-off so the unit backs up into its input
   initial begin
      wait (cycle >= HOLD_AT);
      hold_off = 1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_off = 0;
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // check each result item against the oldest expectation, then pick the next stall
   always @(posedge clock) begin
      frame_type f;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $error("result item with no expectation pending");
               errors++;
            end else begin
               f = frames_due.pop_front();
               check_field("tangent_x", int'(f.tx), int'(rsp_tangent_x));
               check_field("tangent_y", int'(f.ty), int'(rsp_tangent_y));
               check_field("tangent_z", int'(f.tz), int'(rsp_tangent_z));
               check_field("binormal_x", int'(f.bx), int'(rsp_binormal_x));
               check_field("binormal_y", int'(f.by), int'(rsp_binormal_y));
               check_field("binormal_z", int'(f.bz), int'(rsp_binormal_z));
               check_field("degenerate", int'(f.degen), int'(rsp_degenerate));
               check_field("last_of_triangle", int'(f.last), int'(rsp_last_of_triangle));
            end
         end
         rsp_stall <= hold_off || (!quiet() && $urandom_range(0, 99) < 35);
      end
   end

   initial begin
      vertex_type a, b, c;
      // plain right triangle, zero determinant, extremes, normal along s,
      // zero normal, flipped winding
      dir_rows[0]  = '{mk(0, 0, 0, 0, 0, 0, 0, 16384), 0};
      dir_rows[1]  = '{mk(QONE, 0, 0, QONE, 0, 0, 0, 16384), 0};
      dir_rows[2]  = '{mk(0, QONE, 0, 0, QONE, 0, 0, 16384), 0};
      dir_rows[3]  = '{mk(0, 0, 0, QONE, QONE, 0, 0, 16384), 0};
      dir_rows[4]  = '{mk(QONE, 0, 0, QONE, QONE, 0, 0, 16384), 0};
      dir_rows[5]  = '{mk(0, QONE, 0, QONE, QONE, 0, 0, 16384), 1};
      dir_rows[6]  = '{mk(-2147483648, -2147483648, -2147483648, -2147483648,
                          -2147483648, -32768, -32768, -32768), 0};
      dir_rows[7]  = '{mk(2147483647, 2147483647, 2147483647, 2147483647,
                          -2147483648, 32767, 32767, 32767), 0};
      dir_rows[8]  = '{mk(2147483647, -2147483648, 0, -2147483648, 2147483647,
                          0, -32768, 32767), 0};
      dir_rows[9]  = '{mk(0, 0, 0, 0, 0, 16384, 0, 0), 0};
      dir_rows[10] = '{mk(QONE, 0, 0, QONE, 0, 16384, 0, 0), 0};
      dir_rows[11] = '{mk(0, QONE, 0, 0, QONE, 16384, 0, 0), 1};
      dir_rows[12] = '{mk(0, 0, 0, 0, 0, 0, 0, 0), 0};
      dir_rows[13] = '{mk(QONE, 0, 0, QONE, 0, 0, 0, 0), 0};
      dir_rows[14] = '{mk(0, QONE, 0, 0, QONE, 0, 0, 0), 1};
      dir_rows[15] = '{mk(0, 0, 0, 0, 0, 0, 16384, 0), 0};
      dir_rows[16] = '{mk(QONE, 0, 0, 0, QONE, 0, 16384, 0), 0};
      dir_rows[17] = '{mk(0, QONE, 0, QONE, 0, 0, 16384, 0), 0};

      repeat (5) @(posedge clock);
      reset <= 0;

      foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].known);

      // random triangles: mostly mesh-like, some full-range, some with zero determinant
      for (int t = 0; t < RAND_TRIS; t++) begin
         a = rand_vertex($urandom_range(0, 9) == 0);
         b = rand_vertex($urandom_range(0, 9) == 0);
         c = rand_vertex($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 15) == 0) begin
            b.tu = a.tu; b.tv = a.tv;
         end
         send_vertex(a, 0);
         send_vertex(b, 0);
         send_vertex(c, 0);
      end
      req_valid <= 0;

      while (frames_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0 && frames_due.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
